>>> hdl/wgh_pkg.sv
package wgh_pkg;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [23:0]        error_value;
    logic               new_batch;
  } in_item_t;

  typedef struct packed {
    logic        in_bounds;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [23:0] weight_added;
    logic [39:0] cell_total;
  } out_item_t;

  localparam logic [1:0] REG_HALF_X    = 2'd0;
  localparam logic [1:0] REG_HALF_Y    = 2'd1;
  localparam logic [1:0] REG_CELL_SIZE = 2'd2;

  localparam int DIV_STEPS = 25;

  typedef struct packed {
    logic load;
    logic div_start;
    logic clear_start;
    logic mem_read;
    logic mem_write;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clear_done;
  } ctrl_sts_t;

endpackage

>>> hdl/wgh_ctrl.sv
module wgh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wgh_pkg::ctrl_sts_t sts,
  output wgh_pkg::ctrl_cmd_t cmd
);
  import wgh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_DIV, S_READ, S_WAIT, S_WRITE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clear_start = 1'b1;
        state_nxt       = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done && sts.clear_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.mem_write = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (out_valid_r && out_ready && !cmd.out_load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

>>> hdl/wgh_datapath.sv
module wgh_datapath #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [18:0]         cfg_data,
  input  wgh_pkg::in_item_t   in_item,
  input  wgh_pkg::ctrl_cmd_t  cmd,
  output wgh_pkg::ctrl_sts_t  sts,
  output wgh_pkg::out_item_t  out_item
);
  import wgh_pkg::*;

  localparam int CW     = $clog2(GRID_COLS);
  localparam int RW     = $clog2(GRID_ROWS);
  localparam int AW     = RW + CW;
  localparam int NROWS_MEM = GRID_ROWS * (2 ** CW);
  localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;

  logic [18:0] hx_r, hy_r;
  logic [15:0] cs_r;
  logic [7:0]  batch_r, batch_nxt;

  logic signed [19:0] x_r, y_r;
  logic [23:0]        err_r;
  logic               nb_r, inb_r, wrap_r;

  logic [19:0] offx_r, offy_r;
  logic [15:0] div_d_r;
  logic [24:0] rem_x_r, rem_y_r, rem_w_r;
  logic [19:0] qx_r, qy_r;
  logic [24:0] qw_r, num_w_r;
  logic [4:0]  step_r;
  logic        div_busy_r;

  logic [AW:0] clr_r;
  logic        clr_busy_r;

  logic [39:0] sums [NROWS_MEM];
  logic [7:0]  tags [NROWS_MEM];
  logic [39:0] rd_sum_r;
  logic [7:0]  rd_tag_r;
  logic [39:0] total_r;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] addr;
  logic [23:0]   weight;
  logic [40:0]   sum_wide;

  logic signed [20:0] xs, ys, hxs, hys;
  logic in_bnd;

  always_comb begin
    xs  = 21'(x_r);
    ys  = 21'(y_r);
    hxs = {2'b00, hx_r};
    hys = {2'b00, hy_r};
    in_bnd = (xs >= -hxs) && (xs <= hxs) && (ys >= -hys) && (ys <= hys);
  end

  always_comb begin
    if (qx_r >= 20'(GRID_COLS - 1)) col = CW'(GRID_COLS - 1);
    else col = qx_r[CW-1:0];
    if (qy_r >= 20'(GRID_ROWS - 1)) row = RW'(GRID_ROWS - 1);
    else row = qy_r[RW-1:0];
    addr = {row, col};
    weight = (qw_r > 25'hFF_FFFF) ? 24'hFF_FFFF : qw_r[23:0];
    sum_wide = ((rd_tag_r == batch_r) ? {1'b0, rd_sum_r} : 41'd0) + 41'(weight);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r <= 19'd2000;
      hy_r <= 19'd2000;
      cs_r <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_X:    hx_r <= cfg_data;
        REG_HALF_Y:    hy_r <= cfg_data;
        REG_CELL_SIZE: cs_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    batch_nxt = batch_r;
    if (cmd.clear_start && nb_r) begin
      batch_nxt = wrap_r ? 8'd1 : batch_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r    <= 8'd1;
      div_busy_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_r      <= '0;
    end else begin
      batch_r <= batch_nxt;
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && step_r == 5'(DIV_STEPS - 1)) begin
        div_busy_r <= 1'b0;
      end
      if (cmd.clear_start && nb_r && wrap_r) begin
        clr_busy_r <= 1'b1;
        clr_r      <= '0;
      end else if (clr_busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == (AW+1)'(NROWS_MEM - 1)) clr_busy_r <= 1'b0;
      end
    end
  end

  // Restoring division: both index quotients and the reciprocal weight share one step counter.
  logic [24:0] wdiv;
  assign wdiv = (err_r == 24'd0) ? 25'd1 : 25'(err_r);
  logic [25:0] tw2;
  assign tw2 = {rem_w_r[24:0], num_w_r[24]} - {1'b0, wdiv};
  logic [25:0] tx2, ty2;
  assign tx2 = {rem_x_r[24:0], offx_r[19]} - 26'(div_d_r);
  assign ty2 = {rem_y_r[24:0], offy_r[19]} - 26'(div_d_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_item.pos_x;
      y_r     <= in_item.pos_y;
      err_r   <= in_item.error_value;
      nb_r    <= in_item.new_batch;
      offx_r  <= 20'(in_item.pos_x) + 20'(hx_r);
      offy_r  <= 20'(in_item.pos_y) + 20'(hy_r);
      div_d_r <= (cs_r == 16'd0) ? 16'd1 : cs_r;
      wrap_r  <= (batch_r == 8'hFF);
    end
    if (cmd.clear_start || cmd.div_start) begin
      step_r <= '0;
    end
    if (cmd.clear_start) begin
      inb_r   <= in_bnd;
      rem_x_r <= '0;
      rem_y_r <= '0;
      rem_w_r <= '0;
      num_w_r <= 25'h100_0000;
      qx_r    <= '0;
      qy_r    <= '0;
      qw_r    <= '0;
    end else if (div_busy_r && !cmd.div_start) begin
      step_r  <= step_r + 5'd1;
      num_w_r <= {num_w_r[23:0], 1'b0};
      if (!tw2[25]) begin
        rem_w_r <= tw2[24:0];
        qw_r    <= {qw_r[23:0], 1'b1};
      end else begin
        rem_w_r <= {rem_w_r[23:0], num_w_r[24]};
        qw_r    <= {qw_r[23:0], 1'b0};
      end
      if (step_r < 5'd20) begin
        offx_r <= {offx_r[18:0], 1'b0};
        offy_r <= {offy_r[18:0], 1'b0};
        if (!tx2[25]) begin
          rem_x_r <= tx2[24:0];
          qx_r    <= {qx_r[18:0], 1'b1};
        end else begin
          rem_x_r <= {rem_x_r[23:0], offx_r[19]};
          qx_r    <= {qx_r[18:0], 1'b0};
        end
        if (!ty2[25]) begin
          rem_y_r <= ty2[24:0];
          qy_r    <= {qy_r[18:0], 1'b1};
        end else begin
          rem_y_r <= {rem_y_r[23:0], offy_r[19]};
          qy_r    <= {qy_r[18:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      tags[clr_r[AW-1:0]] <= 8'd0;
    end else if (cmd.mem_write && inb_r) begin
      tags[addr] <= batch_r;
    end
    if (cmd.mem_read) begin
      rd_tag_r <= tags[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write && inb_r) begin
      sums[addr] <= total_r;
    end
    if (cmd.mem_read) begin
      rd_sum_r <= sums[addr];
    end
  end

  always_ff @(posedge clk) begin
    total_r <= sum_wide[40] ? SUM_MAX : sum_wide[39:0];
    if (cmd.out_load) begin
      out_item.in_bounds    <= inb_r;
      out_item.cell_row     <= inb_r ? 6'(row) : 6'd0;
      out_item.cell_col     <= inb_r ? 6'(col) : 6'd0;
      out_item.weight_added <= inb_r ? weight : 24'd0;
      out_item.cell_total   <= inb_r ? total_r : 40'd0;
    end
  end

  assign sts.div_done   = !div_busy_r;
  assign sts.clear_done = !clr_busy_r;
endmodule

>>> hdl/weighted_grid_histogram.sv
// Channel  Ports                      Payload
// in       in_valid / in_ready        in_item  (pos_x, pos_y, error_value, new_batch)
// out      out_valid / out_ready      out_item (in_bounds, cell_row, cell_col,
//                                              weight_added, cell_total)
// cfg      cfg_we, cfg_index          cfg_data
// A result is loaded after its item is accepted: a set-up state, 25 steps of the shared
// restoring divider, a completion check, then memory read, wait and write.
// The input is not ready while an item is in work.
// After reset, and when the batch tag wraps, a clearing pass writes every one of the
// GRID_ROWS times 2^ceil(log2 GRID_COLS) tag entries before work continues.
// The result register holds a finished item while the output is stalled.
module weighted_grid_histogram #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wgh_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output wgh_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [18:0]        cfg_data
);
  import wgh_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  wgh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  wgh_datapath #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_item, .cmd, .sts, .out_item
  );
endmodule

>>> verif/wgh_checker.sv
module wgh_checker #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  wgh_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  wgh_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [18:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import wgh_pkg::*;

  localparam int NCELLS = GRID_ROWS * GRID_COLS;
  localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;

  logic [18:0] half_x, half_y;
  logic [15:0] cell_edge;
  logic [39:0] sums [NCELLS];
  logic [7:0]  tags [NCELLS];
  logic [7:0]  batch;
  out_item_t   expected_results [$];

  function automatic longint unsigned bin_index(longint signed pos, longint signed half,
                                                longint unsigned edge_len,
                                                longint unsigned count);
    longint unsigned idx;
    idx = longint'(pos + half) / edge_len;
    if (idx > count - 1) idx = count - 1;
    return idx;
  endfunction

  function automatic out_item_t bin_item(in_item_t it);
    out_item_t r;
    longint signed x, y, hx, hy;
    longint unsigned edge_len, row, col, w, total, old;
    int cell_idx;
    r = '0;
    x = it.pos_x;
    y = it.pos_y;
    hx = half_x;
    hy = half_y;
    edge_len = (cell_edge == 0) ? 1 : cell_edge;
    if (it.new_batch) begin
      if (batch == 8'hFF) begin
        foreach (tags[i]) tags[i] = '0;
        batch = 8'd1;
      end else begin
        batch = batch + 8'd1;
      end
    end
    if (x < -hx || x > hx || y < -hy || y > hy) return r;
    col = bin_index(x, hx, edge_len, GRID_COLS);
    row = bin_index(y, hy, edge_len, GRID_ROWS);
    cell_idx = int'(row * GRID_COLS + col);
    w = (64'd1 << 24) / ((it.error_value == 0) ? 64'd1 : 64'(it.error_value));
    if (w > 64'hFF_FFFF) w = 64'hFF_FFFF;
    old = (tags[cell_idx] == batch) ? sums[cell_idx] : 0;
    total = old + w;
    if (total > SUM_MAX) total = SUM_MAX;
    sums[cell_idx] = total[39:0];
    tags[cell_idx] = batch;
    r.in_bounds = 1'b1;
    r.cell_row = row[5:0];
    r.cell_col = col[5:0];
    r.weight_added = w[23:0];
    r.cell_total = total[39:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      half_x <= 19'd2000;
      half_y <= 19'd2000;
      cell_edge <= 16'd100;
      foreach (tags[i]) tags[i] = '0;
      batch = 8'd1;
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_X:    half_x <= cfg_data;
          REG_HALF_Y:    half_y <= cfg_data;
          REG_CELL_SIZE: cell_edge <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(bin_item(in_item));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("Result with nothing expected: %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item !== exp_r) begin
            if (fail_count < 10)
              $display("Mismatch: expected %p, got %p", exp_r, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_results.size();
    end
  end
endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wgh_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_HALF_X;
  logic [18:0] cfg_data = '0;
  int fail_count, pending_count, result_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int sent_count = 0;
  int set_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  weighted_grid_histogram dut (.*);

  wgh_checker checker_i (.*);

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [18:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    set_count++;
  endtask

  task automatic set_grid(logic [18:0] hx, logic [18:0] hy, logic [18:0] edge_len);
    write_reg(REG_HALF_X, hx);
    write_reg(REG_HALF_Y, hy);
    write_reg(REG_CELL_SIZE, edge_len);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic signed [19:0] x, logic signed [19:0] y,
                                         logic [23:0] err, logic nb);
    in_item_t it;
    it.pos_x = x;
    it.pos_y = y;
    it.error_value = err;
    it.new_batch = nb;
    return it;
  endfunction

  function automatic logic [23:0] rand_error();
    case ($urandom_range(3))
      0: return 24'($urandom_range(3));
      1: return 24'($urandom_range(4096));
      2: return 24'($urandom_range(16777215));
      default: return 24'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic signed [19:0] rand_pos(int half);
    if ($urandom_range(9) == 0) return 20'($urandom);
    if ($urandom_range(9) == 0) return ($urandom_range(1)) ? 20'(half) : -20'(half);
    return 20'(int'($urandom_range(2 * half)) - half);
  endfunction

  task automatic random_phase(int count, int hx, int hy);
    for (int i = 0; i < count; i++)
      send_item(make_item(rand_pos(hx), rand_pos(hy), rand_error(),
                          $urandom_range(19) == 0));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(0, 0, 0, 1'b0));
    send_item(make_item(0, 0, 1, 1'b0));
    send_item(make_item(0, 0, 24'hFFFFFF, 1'b0));
    send_item(make_item(2000, 2000, 4096, 1'b0));
    send_item(make_item(-2000, -2000, 4096, 1'b0));
    send_item(make_item(2001, 0, 4096, 1'b0));
    send_item(make_item(0, -2001, 4096, 1'b0));
    send_item(make_item(20'sh7FFFF, 20'sh80000, 2, 1'b0));
    send_item(make_item(0, 0, 3, 1'b1));
    send_item(make_item(1999, -1999, 4097, 1'b0));
    drain();

    set_grid(19'h7FFFF, 19'h7FFFF, 19'd1);
    send_item(make_item(20'sh7FFFF, 20'sh7FFFF, 0, 1'b1));
    send_item(make_item(20'sh80000, 20'sh80000, 0, 1'b0));
    send_item(make_item(20'sh80000, 20'sh7FFFF, 5, 1'b0));
    drain();
    set_grid(19'd1, 19'd1, 19'hFFFF);
    send_item(make_item(1, -1, 0, 1'b1));
    send_item(make_item(-1, 1, 0, 1'b0));
    send_item(make_item(2, 0, 0, 1'b0));
    drain();
    set_grid(19'd5, 19'd7, 19'd0);
    send_item(make_item(5, 7, 7, 1'b0));
    send_item(make_item(-5, -7, 7, 1'b0));
    drain();

    // Pile full weights into the only reachable cell of a grid with zero half-extents.
    set_grid(19'd0, 19'd0, 19'd1);
    for (int i = 0; i < 8; i++) send_item(make_item(0, 0, 0, 1'b0));
    drain();

    set_grid(19'd3000, 19'd1500, 19'd50);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_phase(65, 3000, 1500);
    drain();

    set_grid(19'd400, 19'd400, 19'd7);
    send_idle_pct = 45; recv_stall_pct = 0;
    random_phase(65, 400, 400);
    drain();

    set_grid(19'd100, 19'd200, 19'd3);
    send_idle_pct = 0; recv_stall_pct = 45;
    fork
      random_phase(65, 100, 200);
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    set_grid(19'd2000, 19'd2000, 19'd100);
    send_idle_pct = 10; recv_stall_pct = 10;
    random_phase(65, 2000, 2000);
    drain();

    // Enough new batches to wrap the batch tag and force a clearing pass.
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 270; i++)
      send_item(make_item(20'(int'($urandom_range(40)) - 20), 0, rand_error(), 1'b1));
    drain();

    $display("Sent %0d items over %0d register writes; %0d results checked.",
             sent_count, set_count, result_count);
    $display("Covered bounds, clamping, zero error, weight limits, batch wrap and stalls.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/wgh_pkg.sv
hdl/wgh_ctrl.sv
hdl/wgh_datapath.sv
hdl/weighted_grid_histogram.sv
verif/wgh_checker.sv
verif/tb.sv
